FILE: src/perf_counter_attack_detector_unit_macros.svh
// Assertion helpers for the attack detector.
// Both sample on clk and are off while rst_n is low.
`ifndef PERF_COUNTER_ATTACK_DETECTOR_UNIT_MACROS_SVH
`define PERF_COUNTER_ATTACK_DETECTOR_UNIT_MACROS_SVH

// same-cycle implication
`define PCAD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PCAD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/pcad_pkg.sv
package pcad_pkg;

  // counter and window geometry; window length is a power of two
  localparam int CNT_W      = 32;
  localparam int WIN_LOG2   = 3;
  localparam int WINDOW_LEN = 1 << WIN_LOG2;
  localparam int SLOT_W     = WIN_LOG2;
  localparam int TOT_W      = CNT_W + WIN_LOG2;
  localparam int LIMIT_W    = 33;

  // compare widths for the cross-multiplied ratios
  localparam int RATIO_W = CNT_W + 4;   // 10 * avg
  localparam int GROW_W  = CNT_W + 7;   // 100 * cur
  localparam int FG_W    = CNT_W + 2;   // 2 * (prev + 1)
  localparam int IPF_W   = CNT_W + 10;  // 1000 * cur

  localparam logic [RATIO_W-1:0] MISS_RATIO_NUM = RATIO_W'(10);
  localparam logic [RATIO_W-1:0] ACC_RATIO_NUM  = RATIO_W'(7);
  localparam logic [GROW_W-1:0]  GROWTH_SCALE   = GROW_W'(100);
  localparam logic [IPF_W-1:0]   PER_INSTR_SCALE = IPF_W'(1000);

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = LIMIT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AVG_MISS_FLOOR    = 2'd0,
    CFG_FAULT_FLOOR       = 2'd1,
    CFG_RECENT_MISS_FLOOR = 2'd2,
    CFG_PAIR_FAULT_LIMIT  = 2'd3
  } cfg_reg_t;

  localparam logic [CNT_W-1:0]   AVG_MISS_FLOOR_RST    = CNT_W'(100000);
  localparam logic [CNT_W-1:0]   FAULT_FLOOR_RST       = CNT_W'(100000);
  localparam logic [CNT_W-1:0]   RECENT_MISS_FLOOR_RST = CNT_W'(10000);
  localparam logic [LIMIT_W-1:0] PAIR_FAULT_LIMIT_RST  = LIMIT_W'(256000);

  // sample held between the window update and the rule checks
  typedef struct packed {
    logic [CNT_W-1:0] instr_count;
    logic [CNT_W-1:0] cache_misses;
    logic [CNT_W-1:0] cur_faults;
    logic [CNT_W-1:0] prev_faults;
    logic             detect_en;
    logic [TOT_W-1:0] access_total;
    logic [TOT_W-1:0] miss_total;
  } stage_t;

endpackage

FILE: src/pcad_channels.sv
interface pcad_in_if;
  logic                        valid;
  logic                        ready;
  logic [pcad_pkg::CNT_W-1:0]  instr_count;
  logic [pcad_pkg::CNT_W-1:0]  cache_accesses;
  logic [pcad_pkg::CNT_W-1:0]  cache_misses;
  logic [pcad_pkg::CNT_W-1:0]  minor_faults;
  logic                        ready_req;

  modport source (output valid, instr_count, cache_accesses, cache_misses, minor_faults,
                  ready_req, input ready);
  modport sink (input valid, instr_count, cache_accesses, cache_misses, minor_faults,
                ready_req, output ready);
endinterface

interface pcad_out_if;
  logic valid;
  logic ready;
  logic cache_attack;
  logic fault_attack;

  modport source (output valid, cache_attack, fault_attack, input ready);
  modport sink (input valid, cache_attack, fault_attack, output ready);
endinterface

interface pcad_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pcad_pkg::CFG_IDX_W-1:0]   index;
  logic [pcad_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/perf_counter_attack_detector_unit.sv
// Cache / page-fault attack detector over performance-counter samples.
//
// in_ch  : one beat per sampling interval (instructions, cache accesses,
//          cache misses, minor faults, ready_req). ready_req low still stores
//          the sample in the window but forces both flags to zero.
// out_ch : one beat per input beat, in order: cache_attack, fault_attack.
// cfg_ch : register writes (0 avg miss floor, 1 fault floor, 2 recent miss
//          floor, 3 pair fault limit); always ready, write only while idle.
//
// Throughput: one beat per cycle unless out_ch stalls. A beat passes the
// sample register (s1), then the result register. The window sums update in
// the accept cycle; the rule compares run on the held sample and load the
// result register when it is free. The sample register acts as a skid
// stage, so a stalled receiver holds one result and one sample in flight.
//
// Reset (rst_n low, synchronous): window, sums, previous fault count and
// ring pointer clear to zero, registers return to their defaults, both
// stages empty.
module perf_counter_attack_detector_unit (
  input  logic              clk,
  input  logic              rst_n,
  pcad_in_if.sink           in_ch,
  pcad_out_if.source        out_ch,
  pcad_cfg_if.sink          cfg_ch
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [pcad_pkg::CNT_W-1:0]   avg_miss_floor_r, avg_miss_floor_nxt;
  logic [pcad_pkg::CNT_W-1:0]   fault_floor_r, fault_floor_nxt;
  logic [pcad_pkg::CNT_W-1:0]   recent_miss_floor_r, recent_miss_floor_nxt;
  logic [pcad_pkg::LIMIT_W-1:0] pair_fault_limit_r, pair_fault_limit_nxt;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    avg_miss_floor_nxt    = avg_miss_floor_r;
    fault_floor_nxt       = fault_floor_r;
    recent_miss_floor_nxt = recent_miss_floor_r;
    pair_fault_limit_nxt  = pair_fault_limit_r;
    if (cfg_ch.valid) begin
      unique case (pcad_pkg::cfg_reg_t'(cfg_ch.index))
        pcad_pkg::CFG_AVG_MISS_FLOOR:    avg_miss_floor_nxt    = cfg_ch.data[pcad_pkg::CNT_W-1:0];
        pcad_pkg::CFG_FAULT_FLOOR:       fault_floor_nxt       = cfg_ch.data[pcad_pkg::CNT_W-1:0];
        pcad_pkg::CFG_RECENT_MISS_FLOOR: recent_miss_floor_nxt = cfg_ch.data[pcad_pkg::CNT_W-1:0];
        pcad_pkg::CFG_PAIR_FAULT_LIMIT:  pair_fault_limit_nxt  = cfg_ch.data;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake: sample stage (s1) feeding the result register
  // ---------------------------------------------------------------------
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free, s1_fire, in_fire;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Window ring and running sums, updated on each input beat
  // ---------------------------------------------------------------------
  logic [pcad_pkg::CNT_W-1:0]  access_win_r [pcad_pkg::WINDOW_LEN];
  logic [pcad_pkg::CNT_W-1:0]  access_win_nxt [pcad_pkg::WINDOW_LEN];
  logic [pcad_pkg::CNT_W-1:0]  miss_win_r [pcad_pkg::WINDOW_LEN];
  logic [pcad_pkg::CNT_W-1:0]  miss_win_nxt [pcad_pkg::WINDOW_LEN];
  logic [pcad_pkg::TOT_W-1:0]  access_total_r, access_total_nxt;
  logic [pcad_pkg::TOT_W-1:0]  miss_total_r, miss_total_nxt;
  logic [pcad_pkg::CNT_W-1:0]  prev_faults_r, prev_faults_nxt;
  logic [pcad_pkg::SLOT_W-1:0] write_slot_r, write_slot_nxt;
  logic [pcad_pkg::SLOT_W-1:0] slot_plus1;
  pcad_pkg::stage_t            s1_r, s1_nxt;

  assign slot_plus1 = write_slot_r + 1'b1;   // wraps at WINDOW_LEN

  always_comb begin
    access_win_nxt   = access_win_r;
    miss_win_nxt     = miss_win_r;
    access_total_nxt = access_total_r;
    miss_total_nxt   = miss_total_r;
    prev_faults_nxt  = prev_faults_r;
    write_slot_nxt   = write_slot_r;
    s1_nxt           = s1_r;
    if (in_fire) begin
      // drop the oldest sample, add the new one
      access_total_nxt = access_total_r
                         - {{pcad_pkg::WIN_LOG2{1'b0}}, access_win_r[write_slot_r]}
                         + {{pcad_pkg::WIN_LOG2{1'b0}}, in_ch.cache_accesses};
      miss_total_nxt   = miss_total_r
                         - {{pcad_pkg::WIN_LOG2{1'b0}}, miss_win_r[write_slot_r]}
                         + {{pcad_pkg::WIN_LOG2{1'b0}}, in_ch.cache_misses};
      access_win_nxt[write_slot_r] = in_ch.cache_accesses;
      miss_win_nxt[write_slot_r]   = in_ch.cache_misses;
      prev_faults_nxt = in_ch.minor_faults;
      write_slot_nxt  = slot_plus1;

      s1_nxt.instr_count  = in_ch.instr_count;
      s1_nxt.cache_misses = in_ch.cache_misses;
      s1_nxt.cur_faults   = in_ch.minor_faults;
      s1_nxt.prev_faults  = prev_faults_r;
      s1_nxt.detect_en    = in_ch.ready_req;
      s1_nxt.access_total = access_total_nxt;
      s1_nxt.miss_total   = miss_total_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Rule checks on the held sample; ratios by cross-multiplication
  // ---------------------------------------------------------------------
  logic [pcad_pkg::CNT_W-1:0]   avg_miss, avg_acc;
  logic [pcad_pkg::RATIO_W-1:0] miss_scaled, acc_scaled;
  logic [pcad_pkg::GROW_W-1:0]  cur_grow, prev_grow;
  logic [pcad_pkg::FG_W-1:0]    cur_fg, prev_fg;
  logic [pcad_pkg::IPF_W-1:0]   cur_ipf, instr_ipf;
  logic [pcad_pkg::LIMIT_W-1:0] pair_sum;
  logic                         cache_hit, fault_hit;
  logic                         cache_r, cache_nxt;
  logic                         fault_r, fault_nxt;

  // truncated window averages
  assign avg_miss = s1_r.miss_total[pcad_pkg::TOT_W-1:pcad_pkg::WIN_LOG2];
  assign avg_acc  = s1_r.access_total[pcad_pkg::TOT_W-1:pcad_pkg::WIN_LOG2];

  // miss ratio above 0.7: 10 * miss > 7 * access
  assign miss_scaled = {{(pcad_pkg::RATIO_W-pcad_pkg::CNT_W){1'b0}}, avg_miss}
                       * pcad_pkg::MISS_RATIO_NUM;
  assign acc_scaled  = {{(pcad_pkg::RATIO_W-pcad_pkg::CNT_W){1'b0}}, avg_acc}
                       * pcad_pkg::ACC_RATIO_NUM;

  // fault growth below 0.01: 100 * cur < prev + 1
  assign cur_grow  = {{(pcad_pkg::GROW_W-pcad_pkg::CNT_W){1'b0}}, s1_r.cur_faults}
                     * pcad_pkg::GROWTH_SCALE;
  assign prev_grow = {{(pcad_pkg::GROW_W-pcad_pkg::CNT_W){1'b0}}, s1_r.prev_faults}
                     + 1'b1;

  // fault growth above 2: cur > 2 * (prev + 1)
  assign cur_fg  = {{(pcad_pkg::FG_W-pcad_pkg::CNT_W){1'b0}}, s1_r.cur_faults};
  assign prev_fg = {1'b0, s1_r.prev_faults, 1'b0} + {{(pcad_pkg::FG_W-2){1'b0}}, 2'b10};

  // faults per instruction above 0.001: 1000 * cur > instr
  assign cur_ipf   = {{(pcad_pkg::IPF_W-pcad_pkg::CNT_W){1'b0}}, s1_r.cur_faults}
                     * pcad_pkg::PER_INSTR_SCALE;
  assign instr_ipf = {{(pcad_pkg::IPF_W-pcad_pkg::CNT_W){1'b0}}, s1_r.instr_count};

  // exact 33-bit sum of the last two fault counts
  assign pair_sum = {1'b0, s1_r.cur_faults} + {1'b0, s1_r.prev_faults};

  assign cache_hit = (miss_scaled > acc_scaled)
                     && (avg_miss > avg_miss_floor_r)
                     && (cur_grow < prev_grow);

  assign fault_hit = ((cur_fg > prev_fg)
                      && (s1_r.cur_faults > fault_floor_r)
                      && (s1_r.cache_misses > recent_miss_floor_r)
                      && (cur_ipf > instr_ipf))
                     || (pair_sum > pair_fault_limit_r);

  always_comb begin
    cache_nxt = cache_r;
    fault_nxt = fault_r;
    if (s1_fire) begin
      cache_nxt = s1_r.detect_en && cache_hit;
      fault_nxt = s1_r.detect_en && fault_hit;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.cache_attack = cache_r;
  assign out_ch.fault_attack = fault_r;

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_miss_floor_r    <= pcad_pkg::AVG_MISS_FLOOR_RST;
      fault_floor_r       <= pcad_pkg::FAULT_FLOOR_RST;
      recent_miss_floor_r <= pcad_pkg::RECENT_MISS_FLOOR_RST;
      pair_fault_limit_r  <= pcad_pkg::PAIR_FAULT_LIMIT_RST;
      s1_valid_r          <= 1'b0;
      out_valid_r         <= 1'b0;
      access_total_r      <= '0;
      miss_total_r        <= '0;
      prev_faults_r       <= '0;
      write_slot_r        <= '0;
      for (int i = 0; i < pcad_pkg::WINDOW_LEN; i++) begin
        access_win_r[i] <= '0;
        miss_win_r[i]   <= '0;
      end
    end else begin
      avg_miss_floor_r    <= avg_miss_floor_nxt;
      fault_floor_r       <= fault_floor_nxt;
      recent_miss_floor_r <= recent_miss_floor_nxt;
      pair_fault_limit_r  <= pair_fault_limit_nxt;
      s1_valid_r          <= s1_valid_nxt;
      out_valid_r         <= out_valid_nxt;
      access_total_r      <= access_total_nxt;
      miss_total_r        <= miss_total_nxt;
      prev_faults_r       <= prev_faults_nxt;
      write_slot_r        <= write_slot_nxt;
      access_win_r        <= access_win_nxt;
      miss_win_r          <= miss_win_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    s1_r    <= s1_nxt;
    cache_r <= cache_nxt;
    fault_r <= fault_nxt;
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `include "perf_counter_attack_detector_unit_macros.svh"

  `PCAD_ASSERT_NEXT(a_slot_step, in_fire, write_slot_r == $past(write_slot_r) + 1'b1, "ring pointer did not step on input beat")
  `PCAD_ASSERT_NEXT(a_sums_hold, !in_fire, $stable(access_total_r) && $stable(miss_total_r), "window sums moved without input beat")
  `PCAD_ASSERT_NEXT(a_disabled_quiet, s1_fire && !s1_r.detect_en, !out_ch.cache_attack && !out_ch.fault_attack, "flag raised with detection disabled")
  `PCAD_ASSERT_NOW(a_empty_ready, !s1_valid_r, in_ch.ready, "input stalled with empty sample stage")

endmodule
